>>> src/scft_pkg.sv
// Shared types and constants for the sparse triplet fast transpose core.
// Depends on nothing; imported by the top level.
`default_nettype none

package scft_pkg;

    localparam int MAX_TERMS   = 64;
    localparam int MAX_DIM     = 256;
    localparam int TERM_AW     = $clog2(MAX_TERMS);
    localparam int CNT_W       = $clog2(MAX_TERMS + 1);
    localparam int TALLY_DEPTH = MAX_DIM + 1;
    localparam int BKT_W       = $clog2(TALLY_DEPTH);
    localparam int NCOL_W      = 9;
    localparam int IDX_W       = 8;
    localparam int VAL_W       = 32;

    // One stored triplet; row sits in the lowest bits.
    typedef struct packed {
        logic signed [VAL_W-1:0] value;
        logic [IDX_W-1:0]        col;
        logic [IDX_W-1:0]        row;
    } term_t;

    localparam int TERM_W = $bits(term_t);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LD_WR,
        ST_PRE_RD,
        ST_PRE_WR,
        ST_SC_RD,
        ST_SC_BK,
        ST_SC_WR,
        ST_EM_RD,
        ST_EM_CAP,
        ST_EM_HOLD,
        ST_CLR
    } state_t;

endpackage

`default_nettype wire

>>> src/scft_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on nothing.
`default_nettype none

module scft_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

>>> src/sparse_triplet_fast_transpose_core.sv
// Top level of the sparse triplet fast transpose core: control sequencer and
// three scft_ram instances. Depends on scft_pkg and scft_ram.
`default_nettype none

// Channel      Direction  Content
// s_axis_*     in         one triplet per transfer; tlast starts the transpose
// m_axis_*     out        one transposed triplet per transfer; tlast ends the run
// cfg_*        in         num_cols register write
//
// A stored load writes the term and reads its tally entry, then writes the
// entry plus one; a term dropped because the store is full skips the tally write.
// After the final transfer the sequencer walks the tally memory to form
// starting slots, reading then writing each entry from zero through the
// effective column count, then scatters each term through ST_SC_RD, ST_SC_BK
// and ST_SC_WR and emits each through ST_EM_RD, ST_EM_CAP and ST_EM_HOLD, which
// waits out any stall on m_axis_tready. A clearing pass over all 257 tally
// entries follows every run and every reset; no input transfer is taken in it.

module sparse_triplet_fast_transpose_core
    import scft_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [47:0] s_axis_tdata,   // orig_row[7:0], orig_col[15:8], orig_value[47:16]
    input  wire logic        s_axis_tlast,   // last_term
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic      [47:0] m_axis_tdata,   // out_row[7:0], out_col[15:8], out_value[47:16]
    output logic             m_axis_tlast,   // out_last
    output logic             m_axis_tuser,   // overflow
    input  wire logic        cfg_we,
    input  wire logic [8:0]  cfg_wdata       // num_cols
);

    // Registers.
    state_t             state_reg, state_next;
    logic [NCOL_W-1:0]  num_cols_reg;
    logic [CNT_W-1:0]   term_count_reg, term_count_next;
    logic               dropped_reg, dropped_next;
    logic [IDX_W-1:0]   ld_col_reg, ld_col_next;
    logic               ld_last_reg, ld_last_next;
    logic [BKT_W-1:0]   walk_reg, walk_next;
    logic [CNT_W-1:0]   acc_reg, acc_next;
    logic [CNT_W-1:0]   idx_reg, idx_next;
    term_t              sc_term_reg, sc_term_next;
    logic [BKT_W-1:0]   bucket_reg, bucket_next;
    term_t              out_data_reg, out_data_next;
    logic               out_valid_reg, out_valid_next;
    logic               out_last_reg, out_last_next;
    logic               out_ovf_reg, out_ovf_next;

    // Memory ports.
    logic               term_we, term_re;
    logic [TERM_AW-1:0] term_waddr, term_raddr;
    term_t              term_wdata, term_rdata;
    logic               tally_we, tally_re;
    logic [BKT_W-1:0]   tally_waddr, tally_raddr;
    logic [CNT_W-1:0]   tally_wdata, tally_rdata;
    logic               slot_we, slot_re;
    logic [TERM_AW-1:0] slot_waddr, slot_raddr;
    term_t              slot_wdata, slot_rdata;

    term_t              in_term;
    logic [NCOL_W-1:0]  nc_eff;
    logic [BKT_W-1:0]   sc_bucket;
    logic               in_xfer, out_xfer;

    assign in_term  = term_t'(s_axis_tdata);
    assign in_xfer  = s_axis_tvalid && s_axis_tready;
    assign out_xfer = m_axis_tvalid && m_axis_tready;

    // Column counts above the largest matrix act as the largest one.
    assign nc_eff = (num_cols_reg > NCOL_W'(MAX_DIM)) ? NCOL_W'(MAX_DIM) : num_cols_reg;

    // Bucket of the term just read back for the scatter: its own column when
    // in range, else the shared bucket after all real columns.
    assign sc_bucket = ({1'b0, term_rdata.col} < BKT_W'(nc_eff)) ?
                       BKT_W'(term_rdata.col) : BKT_W'(nc_eff);

    scft_ram #(.WIDTH(TERM_W), .DEPTH(MAX_TERMS)) u_term_ram (
        .clk   (clk),
        .we    (term_we),
        .waddr (term_waddr),
        .wdata (term_wdata),
        .re    (term_re),
        .raddr (term_raddr),
        .rdata (term_rdata)
    );

    // Holds per-column counts during loading and running start slots during
    // the scatter.
    scft_ram #(.WIDTH(CNT_W), .DEPTH(TALLY_DEPTH)) u_tally_ram (
        .clk   (clk),
        .we    (tally_we),
        .waddr (tally_waddr),
        .wdata (tally_wdata),
        .re    (tally_re),
        .raddr (tally_raddr),
        .rdata (tally_rdata)
    );

    // Transposed triplets in output order.
    scft_ram #(.WIDTH(TERM_W), .DEPTH(MAX_TERMS)) u_slot_ram (
        .clk   (clk),
        .we    (slot_we),
        .waddr (slot_waddr),
        .wdata (slot_wdata),
        .re    (slot_re),
        .raddr (slot_raddr),
        .rdata (slot_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLR;
            num_cols_reg   <= NCOL_W'(MAX_DIM);
            term_count_reg <= '0;
            dropped_reg    <= 1'b0;
            walk_reg       <= '0;
            acc_reg        <= '0;
            idx_reg        <= '0;
            out_valid_reg  <= 1'b0;
            ld_last_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            term_count_reg <= term_count_next;
            dropped_reg    <= dropped_next;
            walk_reg       <= walk_next;
            acc_reg        <= acc_next;
            idx_reg        <= idx_next;
            out_valid_reg  <= out_valid_next;
            ld_last_reg    <= ld_last_next;
            if (cfg_we)
            begin
                num_cols_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        ld_col_reg   <= ld_col_next;
        sc_term_reg  <= sc_term_next;
        bucket_reg   <= bucket_next;
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
        out_ovf_reg  <= out_ovf_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        term_count_next = term_count_reg;
        dropped_next    = dropped_reg;
        ld_col_next     = ld_col_reg;
        ld_last_next    = ld_last_reg;
        walk_next       = walk_reg;
        acc_next        = acc_reg;
        idx_next        = idx_reg;
        sc_term_next    = sc_term_reg;
        bucket_next     = bucket_reg;
        out_data_next   = out_data_reg;
        out_valid_next  = out_valid_reg;
        out_last_next   = out_last_reg;
        out_ovf_next    = out_ovf_reg;

        s_axis_tready = 1'b0;
        term_we       = 1'b0;
        term_waddr    = term_count_reg[TERM_AW-1:0];
        term_wdata    = in_term;
        term_re       = 1'b0;
        term_raddr    = idx_reg[TERM_AW-1:0];
        tally_we      = 1'b0;
        tally_waddr   = walk_reg;
        tally_wdata   = '0;
        tally_re      = 1'b0;
        tally_raddr   = walk_reg;
        slot_we       = 1'b0;
        slot_waddr    = tally_rdata[TERM_AW-1:0];
        slot_wdata    = '{value: sc_term_reg.value, col: sc_term_reg.row, row: sc_term_reg.col};
        slot_re       = 1'b0;
        slot_raddr    = idx_reg[TERM_AW-1:0];

        unique case (state_reg)
            ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (in_xfer)
                begin
                    ld_col_next  = in_term.col;
                    ld_last_next = s_axis_tlast;
                    if (term_count_reg < CNT_W'(MAX_TERMS))
                    begin
                        term_we     = 1'b1;
                        tally_re    = 1'b1;
                        tally_raddr = BKT_W'(in_term.col);
                        state_next  = ST_LD_WR;
                    end
                    else
                    begin
                        // Store full: the term is dropped and the run is flagged.
                        dropped_next = 1'b1;
                        if (s_axis_tlast)
                        begin
                            walk_next  = '0;
                            acc_next   = '0;
                            state_next = ST_PRE_RD;
                        end
                    end
                end
            end

            ST_LD_WR:
            begin
                tally_we        = 1'b1;
                tally_waddr     = BKT_W'(ld_col_reg);
                tally_wdata     = tally_rdata + CNT_W'(1);
                term_count_next = term_count_reg + CNT_W'(1);
                if (ld_last_reg)
                begin
                    walk_next  = '0;
                    acc_next   = '0;
                    state_next = ST_PRE_RD;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_PRE_RD:
            begin
                tally_re   = 1'b1;
                state_next = ST_PRE_WR;
            end

            ST_PRE_WR:
            begin
                // Replace the count by its exclusive prefix sum. The entry at
                // nc_eff collects every out-of-range column, which were counted
                // under their own columns and so follow all in-range ones.
                tally_we    = 1'b1;
                tally_wdata = acc_reg;
                acc_next    = acc_reg + tally_rdata;
                if (walk_reg == BKT_W'(nc_eff))
                begin
                    idx_next   = '0;
                    state_next = ST_SC_RD;
                end
                else
                begin
                    walk_next  = walk_reg + BKT_W'(1);
                    state_next = ST_PRE_RD;
                end
            end

            ST_SC_RD:
            begin
                term_re    = 1'b1;
                state_next = ST_SC_BK;
            end

            ST_SC_BK:
            begin
                sc_term_next = term_rdata;
                bucket_next  = sc_bucket;
                tally_re     = 1'b1;
                tally_raddr  = sc_bucket;
                state_next   = ST_SC_WR;
            end

            ST_SC_WR:
            begin
                slot_we     = 1'b1;
                tally_we    = 1'b1;
                tally_waddr = bucket_reg;
                tally_wdata = tally_rdata + CNT_W'(1);
                if (idx_reg + CNT_W'(1) == term_count_reg)
                begin
                    idx_next   = '0;
                    state_next = ST_EM_RD;
                end
                else
                begin
                    idx_next   = idx_reg + CNT_W'(1);
                    state_next = ST_SC_RD;
                end
            end

            ST_EM_RD:
            begin
                slot_re    = 1'b1;
                state_next = ST_EM_CAP;
            end

            ST_EM_CAP:
            begin
                out_data_next  = slot_rdata;
                out_valid_next = 1'b1;
                out_last_next  = (idx_reg + CNT_W'(1) == term_count_reg);
                out_ovf_next   = dropped_reg;
                state_next     = ST_EM_HOLD;
            end

            ST_EM_HOLD:
            begin
                if (out_xfer)
                begin
                    out_valid_next = 1'b0;
                    idx_next       = idx_reg + CNT_W'(1);
                    if (out_last_reg)
                    begin
                        walk_next  = '0;
                        state_next = ST_CLR;
                    end
                    else
                    begin
                        state_next = ST_EM_RD;
                    end
                end
            end

            ST_CLR:
            begin
                // Zero every tally entry for the next run.
                tally_we    = 1'b1;
                tally_wdata = '0;
                if (walk_reg == BKT_W'(TALLY_DEPTH - 1))
                begin
                    term_count_next = '0;
                    dropped_next    = 1'b0;
                    state_next      = ST_IDLE;
                end
                else
                begin
                    walk_next = walk_reg + BKT_W'(1);
                end
            end

            default:
            begin
                state_next = ST_CLR;
            end
        endcase
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tuser  = out_ovf_reg;

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        term_count_reg <= CNT_W'(MAX_TERMS))
        else $error("term count exceeds capacity");

    a_store_only_below_cap: assert property (@(posedge clk) disable iff (!rst_n)
        term_we |-> term_count_reg < CNT_W'(MAX_TERMS))
        else $error("term written while the store is full");

    a_slot_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SC_WR |-> tally_rdata < term_count_reg)
        else $error("scatter slot beyond the stored terms");

    a_valid_only_emitting: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> state_reg == ST_EM_HOLD)
        else $error("result shown outside the emit hold state");

    a_last_then_clear: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tready && m_axis_tlast |=> state_reg == ST_CLR)
        else $error("final transfer not followed by the clearing pass");
`endif

endmodule

`default_nettype wire

>>> bench/triplet_transpose_checker.sv
// Checker for the sparse triplet fast transpose core. It watches the input, output and
// configuration channels, predicts every transposed triplet and compares the results.
// Depends on scft_pkg for the triplet layout and the store depth.

module triplet_transpose_checker
    import scft_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,
    input  logic        s_axis_tlast,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [47:0] m_axis_tdata,
    input  logic        m_axis_tlast,
    input  logic        m_axis_tuser,
    input  logic        cfg_we,
    input  logic [8:0]  cfg_wdata,
    output int          mismatches,
    output int          outstanding
);

    typedef struct {
        term_t data;
        logic  last;
        logic  ovf;
    } transposed_t;

    logic [8:0]  col_limit = 9'd256;
    term_t       stored_terms [MAX_TERMS];
    int          stored_count = 0;
    logic        terms_dropped = 1'b0;
    transposed_t expected_triplets [$];

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (mismatches < 40)
            $display("[%0t] mismatch on %s: got %0h, want %0h", $realtime, what, got, want);
        mismatches++;
    endtask

    // Stable counting sort: buckets in ascending order, the shared bucket of
    // out-of-range columns last, input order kept inside every bucket.
    task automatic predict_transpose();
        int          eff;
        int          k;
        transposed_t one;
        transposed_t run_out [$];
        eff = (col_limit > MAX_DIM) ? MAX_DIM : int'(col_limit);
        for (int b = 0; b <= eff; b++)
        begin
            for (int i = 0; i < stored_count; i++)
            begin
                k = (stored_terms[i].col < eff) ? int'(stored_terms[i].col) : eff;
                if (k == b)
                begin
                    one.data.row   = stored_terms[i].col;
                    one.data.col   = stored_terms[i].row;
                    one.data.value = stored_terms[i].value;
                    one.last       = 1'b0;
                    one.ovf        = terms_dropped;
                    run_out        = {run_out, one};
                end
            end
        end
        run_out[run_out.size() - 1].last = 1'b1;
        expected_triplets = {expected_triplets, run_out};
    endtask

    task automatic load_term();
        if (stored_count < MAX_TERMS)
        begin
            stored_terms[stored_count] = term_t'(s_axis_tdata);
            stored_count++;
        end
        else
        begin
            terms_dropped = 1'b1;
        end
        if (s_axis_tlast)
        begin
            predict_transpose();
            stored_count  = 0;
            terms_dropped = 1'b0;
        end
    endtask

    task automatic check_result();
        term_t       got;
        transposed_t want;
        got = term_t'(m_axis_tdata);
        if (expected_triplets.size() == 0)
        begin
            report_mismatch("unexpected result, row/col", 32'({got.row, got.col}), 32'd0);
        end
        else
        begin
            want = expected_triplets.pop_front();
            if (got.row !== want.data.row)
                report_mismatch("out_row", 32'(got.row), 32'(want.data.row));
            if (got.col !== want.data.col)
                report_mismatch("out_col", 32'(got.col), 32'(want.data.col));
            if (got.value !== want.data.value)
                report_mismatch("out_value", got.value, want.data.value);
            if (m_axis_tlast !== want.last)
                report_mismatch("out_last", 32'(m_axis_tlast), 32'(want.last));
            if (m_axis_tuser !== want.ovf)
                report_mismatch("overflow", 32'(m_axis_tuser), 32'(want.ovf));
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_we)
                col_limit = cfg_wdata;
            if (m_axis_tvalid && m_axis_tready)
                check_result();
            if (s_axis_tvalid && s_axis_tready)
                load_term();
        end
        outstanding <= expected_triplets.size();
    end

endmodule

>>> bench/tb_sparse_triplet_fast_transpose_core.sv
// Top of the testbench for the sparse triplet fast transpose core: clock, reset,
// stimulus on the input stream, random back-pressure on the output and the verdict.
// Depends on scft_pkg, the core and triplet_transpose_checker.

module tb_sparse_triplet_fast_transpose_core
    import scft_pkg::*;
();

    // The run is cut off here.
    localparam int CYCLE_LIMIT = 1_000_000;
    // Covers the clearing pass that follows every run and reset.
    localparam int SETTLE_CYCLES = 300;
    // Length of the one long receiver hold-off.
    localparam int HOLD_CYCLES = 500;
    localparam int RANDOM_ITEMS = 288;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata = '0;     // orig_row[7:0], orig_col[15:8], orig_value[47:16]
    logic        s_axis_tlast = 1'b0;   // last_term
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;          // out_row[7:0], out_col[15:8], out_value[47:16]
    logic        m_axis_tlast;          // out_last
    logic        m_axis_tuser;          // overflow
    logic        cfg_we = 1'b0;
    logic [8:0]  cfg_wdata = 9'd256;    // num_cols

    int          mismatches;
    int          outstanding;
    int          cycles = 0;
    bit          tx_eager = 1'b0;
    logic        squeeze_go = 1'b0;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    sparse_triplet_fast_transpose_core i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata)
    );

    triplet_transpose_checker i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .mismatches    (mismatches),
        .outstanding   (outstanding)
    );

    // Idle length shared by both sides: mostly none or short, now and then long.
    function automatic int idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 96)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    // Values lean on the two's complement extremes, zero and minus one.
    function automatic logic [31:0] term_value();
        case ($urandom_range(0, 9))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h0000_0000;
            3: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // Offers one triplet and returns in the time step of the edge that takes it.
    // tvalid stays high on return so that a following call with no gap keeps
    // the stream dense; whoever stops sending has to lower it.
    task automatic send_term(input logic [7:0] row, input logic [7:0] col,
                             input logic [31:0] value, input logic last);
        int gap;
        gap = tx_eager ? 0 : idle_gap();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {value, col, row};
        s_axis_tlast  <= last;
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    // The register is only written while the core is idle: every expected
    // result has arrived and the clearing pass after the run is over.
    task automatic set_num_cols(input logic [8:0] value);
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // One matrix of len terms. Columns mostly fall from zero to just past the column
    // count so that buckets collide and stability matters; a quarter span the full range.
    task automatic send_run(input int len, input int ncols);
        int hi;
        tx_eager = ($urandom_range(0, 3) == 0);
        hi = (ncols >= 255) ? 255 : ncols + 1;
        for (int i = 0; i < len; i++)
        begin
            send_term(8'($urandom_range(0, 255)),
                      8'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                                     : $urandom_range(0, hi)),
                      term_value(), i == len - 1);
        end
    endtask

    function automatic int pick_setting(input int phase);
        case (phase % 8)
            0: return 256;
            1: return 1;
            2: return 0;
            3: return 511;
            4: return $urandom_range(2, 255);
            5: return 255;
            6: return 257;
            default: return $urandom_range(1, 8);
        endcase
    endfunction

    // Receiver: random stalls with eager stretches, plus one long hold-off
    // that makes the core sit on a result while the sender keeps offering.
    initial
    begin : receiver
        int stall;
        int served;
        bit rx_eager;
        bit squeezed;
        served   = 0;
        rx_eager = 1'b0;
        squeezed = 1'b0;
        forever
        begin
            if (served % 32 == 0)
                rx_eager = ($urandom_range(0, 3) == 0);
            if (squeeze_go && !squeezed)
            begin
                m_axis_tready <= 1'b0;
                do
                    @(posedge clk);
                while (!m_axis_tvalid);
                repeat (HOLD_CYCLES) @(posedge clk);
                squeezed = 1'b1;
            end
            else
            begin
                stall = rx_eager ? 0 : idle_gap();
                if (stall > 0)
                begin
                    m_axis_tready <= 1'b0;
                    repeat (stall) @(posedge clk);
                end
            end
            m_axis_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_axis_tvalid);
            served++;
        end
    end

    // Watchdog: a hung handshake ends the run here.
    initial
    begin : watchdog
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("tb_sparse_triplet_fast_transpose_core: FAIL");
        $finish;
    end

    initial
    begin : stimulus
        int random_items;
        int phase;
        int ncols;
        int nruns;
        int len;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part. Full-width columns first: a lone term carrying the most
        // negative value, then the index extremes with ties inside a column.
        set_num_cols(9'd256);
        send_term(8'd0, 8'd0, 32'h8000_0000, 1'b1);
        send_term(8'd255, 8'd255, 32'h7FFF_FFFF, 1'b0);
        send_term(8'd0, 8'd255, 32'hFFFF_FFFF, 1'b0);
        send_term(8'd128, 8'd0, 32'h0000_0001, 1'b0);
        send_term(8'd1, 8'd0, 32'h0000_0002, 1'b0);
        send_term(8'd255, 8'd128, 32'h0000_0000, 1'b0);
        send_term(8'd0, 8'd128, 32'h5555_5555, 1'b0);
        send_term(8'd127, 8'd1, 32'hAAAA_AAAA, 1'b1);

        // Four columns: columns four and up share the trailing bucket and keep
        // their own numbers in out_row.
        set_num_cols(9'd4);
        send_term(8'd10, 8'd3, 32'h0000_0003, 1'b0);
        send_term(8'd11, 8'd4, 32'h0000_0004, 1'b0);
        send_term(8'd12, 8'd255, 32'h0000_00FF, 1'b0);
        send_term(8'd13, 8'd0, 32'h0000_0000, 1'b0);
        send_term(8'd14, 8'd2, 32'h0000_0002, 1'b0);
        send_term(8'd15, 8'd4, 32'h8000_0004, 1'b0);
        send_term(8'd16, 8'd1, 32'h0000_0001, 1'b1);

        // A count of one: only column zero has a bucket of its own.
        set_num_cols(9'd1);
        send_term(8'd200, 8'd1, 32'h1111_1111, 1'b0);
        send_term(8'd201, 8'd0, 32'h2222_2222, 1'b0);
        send_term(8'd202, 8'd0, 32'h3333_3333, 1'b0);
        send_term(8'd203, 8'd200, 32'h4444_4444, 1'b1);

        // Zero columns puts everything in one bucket, so input order comes out.
        set_num_cols(9'd0);
        send_term(8'd7, 8'd9, 32'hDEAD_BEEF, 1'b0);
        send_term(8'd8, 8'd0, 32'h0BAD_F00D, 1'b0);
        send_term(8'd9, 8'd3, 32'h0000_0042, 1'b1);

        // A count above the matrix size acts as the full size.
        set_num_cols(9'd511);
        send_term(8'd5, 8'd255, 32'h0000_0005, 1'b0);
        send_term(8'd6, 8'd0, 32'h0000_0006, 1'b1);

        // Random part: phases over a spread of column counts, a few runs each.
        // Phase 1 fills the store exactly and carries the long receiver hold-off;
        // phases 3 and 5 overrun it, so the final term itself is dropped.
        random_items = 0;
        phase = 0;
        while (random_items < RANDOM_ITEMS)
        begin
            ncols = pick_setting(phase);
            set_num_cols(ncols[8:0]);
            nruns = (phase == 1) ? 2 : $urandom_range(1, 3);
            for (int r = 0; r < nruns; r++)
            begin
                len = $urandom_range(1, 12);
                if (r == 0 && phase == 1)
                begin
                    len = MAX_TERMS;
                    squeeze_go <= 1'b1;
                end
                else if (r == 0 && phase == 3)
                begin
                    len = MAX_TERMS + 1;
                end
                else if (r == 0 && phase == 5)
                begin
                    len = MAX_TERMS + 3;
                end
                send_run(len, ncols);
                random_items += len;
            end
            phase++;
        end

        // Drain: every expected result, then the clearing pass.
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (mismatches == 0 && outstanding == 0)
            $display("tb_sparse_triplet_fast_transpose_core: PASS");
        else
            $display("tb_sparse_triplet_fast_transpose_core: FAIL");
        $finish;
    end

endmodule
